@@ rtl/core/acp_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, character codes and constants of the ASCII motor command parser.
// No dependencies; imported by every module of the block.
package acp_pkg;

	// Default number of fraction digits kept in the value
	localparam int FRAC_DIGITS_DEF = 3;

	// Configuration register reset values
	localparam logic [15:0] DELAY_MIN_RST = 16'd100;
	localparam logic [15:0] DELAY_MAX_RST = 16'd5000;

	// Configuration register indexes
	typedef logic cfg_idx_t;
	localparam cfg_idx_t REG_DELAY_MIN = 1'b0;
	localparam cfg_idx_t REG_DELAY_MAX = 1'b1;

	// Character codes
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_N     = 8'h4E;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_B     = 8'h42;
	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_STAR  = 8'h2A;

	// Run mode codes
	typedef logic [2:0] mode_t;
	localparam mode_t MODE_NONE  = 3'd0;
	localparam mode_t MODE_PLUS  = 3'd1;
	localparam mode_t MODE_MINUS = 3'd2;
	localparam mode_t MODE_P     = 3'd3;
	localparam mode_t MODE_N     = 3'd4;
	localparam mode_t MODE_A     = 3'd5;
	localparam mode_t MODE_B     = 3'd6;
	localparam mode_t MODE_R     = 3'd7;

	// One finished command as it leaves the parser
	typedef struct packed {
		logic [31:0] value;
		mode_t       mode;
		logic        stop;
		logic        pulse_clr;
		logic        dly_req;
	} cmd_t;

	// Power of ten, evaluated on constants only
	function automatic logic [31:0] pow10_f(input int n);
		logic [31:0] r;
		r = 32'd1;
		for (int k = 0; k < n; k++) begin
			r = r * 32'd10;
		end
		return r;
	endfunction

endpackage

@@ rtl/core/acp_parser.sv @@
`timescale 1ns / 1ps
// Byte input register, per-command parse state and finished-command register.
// Depends on acp_pkg.
module acp_parser #(
	parameter int FRAC_DIGITS = acp_pkg::FRAC_DIGITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rx_valid,
	output logic              rx_ready,
	input  logic [7:0]        rx_byte,
	output logic              cmd_valid,
	input  logic              cmd_ready,
	output acp_pkg::cmd_t     cmd
);
	import acp_pkg::*;

	localparam logic [31:0] SCALE = pow10_f(FRAC_DIGITS);
	localparam int          WW    = $clog2(pow10_f(FRAC_DIGITS - 1) + 32'd1);
	localparam int          PW    = $clog2(FRAC_DIGITS + 1);

	// Fraction weight per digit position; zero past the last kept digit
	logic [WW-1:0] wtab [0:FRAC_DIGITS];
	for (genvar k = 0; k <= FRAC_DIGITS; k++) begin : g_wtab
		assign wtab[k] = (k < FRAC_DIGITS) ? WW'(pow10_f(FRAC_DIGITS - 1 - k)) : '0;
	end

	logic [7:0]    byte_s1;
	logic          valid_s1;
	logic [31:0]   value_q;
	logic          frac_q;
	logic [PW-1:0] pos_q;
	mode_t         mode_q;
	logic          stop_q;
	logic          dreq_q;
	logic          pclr_q;
	cmd_t          cmd_s2;
	logic          valid_s2;

	logic          is_digit;
	logic          is_star;
	logic [3:0]    digit;
	logic [36:0]   int_sum;
	logic [33:0]   frac_sum;
	logic [31:0]   int_val;
	logic [31:0]   frac_val;
	logic          s2_free;
	logic          s1_adv;

	// Decode the held beat and form both digit updates
	always_comb begin
		is_digit = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);
		is_star  = (byte_s1 == CH_STAR);
		digit    = 4'(byte_s1 - CH_ZERO);
		int_sum  = (37'(value_q) << 3) + (37'(value_q) << 1) + 37'(digit) * 37'(SCALE);
		frac_sum = 34'(value_q) + 34'(digit) * 34'(wtab[pos_q]);
		int_val  = (|int_sum[36:32]) ? '1 : int_sum[31:0];
		frac_val = (|frac_sum[33:32]) ? '1 : frac_sum[31:0];
	end

	// Advance unless a finished command has nowhere to go
	assign s2_free  = !valid_s2 || cmd_ready;
	assign s1_adv   = valid_s1 && (!is_star || s2_free);
	assign rx_ready = !valid_s1 || s1_adv;

	// Hold the incoming beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && rx_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	// Update the parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
			frac_q  <= 1'b0;
			pos_q   <= '0;
			mode_q  <= MODE_NONE;
			stop_q  <= 1'b0;
			dreq_q  <= 1'b0;
			pclr_q  <= 1'b0;
		end else if (s1_adv) begin
			if (is_digit) begin
				if (!frac_q) begin
					value_q <= int_val;
				end else begin
					value_q <= frac_val;
					if (pos_q != PW'(FRAC_DIGITS)) begin
						pos_q <= pos_q + PW'(1);
					end
				end
			end else begin
				unique case (byte_s1)
					CH_POINT: begin
						frac_q <= 1'b1;
						pos_q  <= '0;
					end
					CH_PLUS:  mode_q <= MODE_PLUS;
					CH_MINUS: mode_q <= MODE_MINUS;
					CH_P:     mode_q <= MODE_P;
					CH_N:     mode_q <= MODE_N;
					CH_A:     mode_q <= MODE_A;
					CH_B: begin
						mode_q <= MODE_B;
						pclr_q <= 1'b1;
					end
					CH_R: begin
						mode_q <= MODE_R;
						pclr_q <= 1'b1;
					end
					CH_S:     stop_q <= 1'b1;
					CH_D:     dreq_q <= 1'b1;
					CH_STAR: begin
						value_q <= '0;
						frac_q  <= 1'b0;
						pos_q   <= '0;
						stop_q  <= 1'b0;
						dreq_q  <= 1'b0;
						pclr_q  <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	// Capture the finished command at the end marker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= s1_adv && is_star;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && s1_adv && is_star) begin
			cmd_s2.value     <= value_q;
			cmd_s2.mode      <= mode_q;
			cmd_s2.stop      <= stop_q;
			cmd_s2.pulse_clr <= pclr_q;
			cmd_s2.dly_req   <= dreq_q;
		end
	end

	assign cmd_valid = valid_s2;
	assign cmd       = cmd_s2;

endmodule

@@ rtl/core/acp_delay.sv @@
`timescale 1ns / 1ps
// Integer-part extraction, delay base clamp and result register.
// Depends on acp_pkg.
module acp_delay #(
	parameter int FRAC_DIGITS = acp_pkg::FRAC_DIGITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  acp_pkg::cmd_t     cmd,
	input  logic [15:0]       delay_min,
	input  logic [15:0]       delay_max,
	output logic              res_valid,
	input  logic              res_ready,
	output logic [31:0]       value_milli,
	output logic [2:0]        run_mode,
	output logic              stop_request,
	output logic              arm_angle_run,
	output logic              clear_pulse_sum,
	output logic              delay_updated,
	output logic [15:0]       delay_base
);
	import acp_pkg::*;

	// Divide by the scale as a multiply by a rounded-up reciprocal
	localparam logic [31:0] SCALE = pow10_f(FRAC_DIGITS);
	localparam int          L     = $clog2(SCALE);
	localparam int          SH    = 32 + L;
	localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(SCALE) - 64'd1) / 64'(SCALE);
	localparam int          QW    = 33 - L;

	logic [64:0]   prod;
	logic [QW-1:0] ip_s3;
	cmd_t          cmd_s3;
	logic          valid_s3;
	logic          out_free;
	logic          s3_free;
	logic          s3_adv;
	logic [31:0]   ip32;
	logic [15:0]   base_new;
	logic [15:0]   base_q;

	logic          res_valid_q;
	logic [31:0]   value_q;
	mode_t         mode_q;
	logic          stop_q;
	logic          arm_q;
	logic          pclr_q;
	logic          upd_q;
	logic [15:0]   res_base_q;

	assign prod = 65'(cmd.value) * 65'(RECIP[32:0]);

	// Stage flow
	assign out_free  = !res_valid_q || res_ready;
	assign s3_adv    = valid_s3 && out_free;
	assign s3_free   = !valid_s3 || out_free;
	assign cmd_ready = s3_free;

	// Register the integer part
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (s3_free) begin
			valid_s3 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_free && cmd_valid) begin
			cmd_s3 <= cmd;
			ip_s3  <= prod[SH +: QW];
		end
	end

	// Clamp the integer part into the delay window
	always_comb begin
		ip32 = 32'(ip_s3);
		if (ip32 <= 32'(delay_min)) begin
			base_new = delay_min;
		end else if (ip32 > 32'(delay_max)) begin
			base_new = delay_max;
		end else begin
			base_new = ip32[15:0];
		end
	end

	// Keep the delay base across commands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= DELAY_MIN_RST;
		end else if (s3_adv && cmd_s3.dly_req) begin
			base_q <= base_new;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_adv) begin
			value_q    <= cmd_s3.value;
			mode_q     <= cmd_s3.mode;
			stop_q     <= cmd_s3.stop;
			arm_q      <= (cmd_s3.mode == MODE_PLUS) || (cmd_s3.mode == MODE_MINUS);
			pclr_q     <= cmd_s3.pulse_clr;
			upd_q      <= cmd_s3.dly_req;
			res_base_q <= cmd_s3.dly_req ? base_new : base_q;
		end
	end

	assign res_valid       = res_valid_q;
	assign value_milli     = value_q;
	assign run_mode        = mode_q;
	assign stop_request    = stop_q;
	assign arm_angle_run   = arm_q;
	assign clear_pulse_sum = pclr_q;
	assign delay_updated   = upd_q;
	assign delay_base      = res_base_q;

endmodule

@@ rtl/core/ascii_motor_command_parser.sv @@
`timescale 1ns / 1ps
// ASCII motor command parser: top level with configuration registers.
// Depends on acp_pkg, acp_parser and acp_delay.
//
// Usage:
//   rx channel (rx_valid/rx_ready/rx_byte) takes one ASCII character per beat.
//   Digits, '.', mode letters and flag letters update the parse state; other
//   bytes are dropped. '*' closes a command and produces one result beat on
//   the res channel (res_valid/res_ready plus the result fields).
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes delay_min
//   (index 0) and delay_max (index 1); cfg_ready is always high. Write it
//   only while no command is in flight.
// Throughput: one byte per cycle while rx_ready is high. Every byte is decoded
//   combinationally from the input register against the parse state.
// Result path: a result shows on res_valid once its '*' has passed the input
//   register, command register, integer-part register and result register.
// Reset: clears the parse state and run mode, sets the delay base and
//   delay_min to 100 and delay_max to 5000.
// Stall: while res_ready is low, bytes other than '*' keep flowing; up to
//   three finished commands queue in the pipe before rx_ready drops.
module ascii_motor_command_parser #(
	parameter int FRAC_DIGITS = acp_pkg::FRAC_DIGITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rx_valid,
	output logic              rx_ready,
	input  logic [7:0]        rx_byte,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  acp_pkg::cfg_idx_t cfg_index,
	input  logic [15:0]       cfg_data,
	output logic              res_valid,
	input  logic              res_ready,
	output logic [31:0]       value_milli,
	output logic [2:0]        run_mode,
	output logic              stop_request,
	output logic              arm_angle_run,
	output logic              clear_pulse_sum,
	output logic              delay_updated,
	output logic [15:0]       delay_base
);
	import acp_pkg::*;

	logic [15:0] dmin_q;
	logic [15:0] dmax_q;
	logic        cmd_valid;
	logic        cmd_ready;
	cmd_t        cmd;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dmin_q <= DELAY_MIN_RST;
			dmax_q <= DELAY_MAX_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DELAY_MIN: dmin_q <= cfg_data;
				REG_DELAY_MAX: dmax_q <= cfg_data;
			endcase
		end
	end

	acp_parser #(
		.FRAC_DIGITS(FRAC_DIGITS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_valid  (rx_valid),
		.rx_ready  (rx_ready),
		.rx_byte   (rx_byte),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	acp_delay #(
		.FRAC_DIGITS(FRAC_DIGITS)
	) u_delay (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_valid       (cmd_valid),
		.cmd_ready       (cmd_ready),
		.cmd             (cmd),
		.delay_min       (dmin_q),
		.delay_max       (dmax_q),
		.res_valid       (res_valid),
		.res_ready       (res_ready),
		.value_milli     (value_milli),
		.run_mode        (run_mode),
		.stop_request    (stop_request),
		.arm_angle_run   (arm_angle_run),
		.clear_pulse_sum (clear_pulse_sum),
		.delay_updated   (delay_updated),
		.delay_base      (delay_base)
	);

	// Input backpressure only ever comes from a stalled result
	a_rx_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!rx_ready |-> (res_valid && !res_ready))
		else $error("rx stalled without a stalled result");

	// Angle-run flag follows the reported mode
	a_arm_mode: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (arm_angle_run == ((run_mode == MODE_PLUS) || (run_mode == MODE_MINUS))))
		else $error("arm_angle_run disagrees with run_mode");

	// The internal command beat is only held when the result side is full
	a_cmd_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_ready) |-> (res_valid && !res_ready))
		else $error("command stage stalled without a stalled result");

endmodule
